// ===== src/external_interrupt_edge_controller_unit_defines.svh =====
// Assertion macros for the external interrupt edge controller.
// Included by RTL files that carry concurrent assertions; no other dependencies.
`ifndef EXTERNAL_INTERRUPT_EDGE_CONTROLLER_UNIT_DEFINES_SVH
`define EXTERNAL_INTERRUPT_EDGE_CONTROLLER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// clocked on clk, held off while rst_n is low
`define EXTI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked on clk, checked during reset as well
`define EXTI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define EXTI_ASSERT(label, prop, msg)
`define EXTI_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== src/exti_pkg.sv =====
// Shared types and constants for the external interrupt edge controller.
// No dependencies.
package exti_pkg;

    localparam int PORT_WIDTH      = 16;
    localparam int LINE_COUNT      = 16;
    localparam int SELECT_WIDTH    = 4;
    localparam int CFG_DATA_WIDTH  = 64;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int IRQ_WIDTH       = 7;
    localparam int LINE_ID_WIDTH   = 4;

    localparam logic [PORT_WIDTH-1:0] LINE_MASK =
        PORT_WIDTH'((33'h1 << LINE_COUNT) - 33'h1);

    localparam logic [PORT_WIDTH-1:0] MID_GROUP_MASK  = 16'h03E0;
    localparam logic [PORT_WIDTH-1:0] HIGH_GROUP_MASK = 16'hFC00;

    localparam int DIRECT_IRQS = 5;
    localparam int MID_LO      = 5;
    localparam int MID_HI      = 9;
    localparam int HIGH_LO     = 10;
    localparam int HIGH_HI     = 15;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_PORT_SELECT = 2'd0,
        CFG_RISE_EN     = 2'd1,
        CFG_FALL_EN     = 2'd2,
        CFG_IRQ_MASK    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PORT_A = 2'd0,
        PORT_B = 2'd1,
        PORT_C = 2'd2,
        PORT_D = 2'd3
    } port_code_t;

    typedef struct packed {
        logic [PORT_WIDTH-1:0]    pending_flags;
        logic [IRQ_WIDTH-1:0]     irq_requests;
        logic [LINE_ID_WIDTH-1:0] next_line_mid;
        logic                     next_mid_valid;
        logic [LINE_ID_WIDTH-1:0] next_line_high;
        logic                     next_high_valid;
    } result_t;

endpackage

// ===== src/external_interrupt_edge_controller_unit.sv =====
// External interrupt edge controller: port select, edge detect, pending bits, irq grouping.
// Depends on exti_pkg and external_interrupt_edge_controller_unit_defines.svh.
//
//  channel | signals                                     | transfer when
//  --------+---------------------------------------------+------------------------
//  in      | in_valid, in_stall, port_*_levels, clear    | in_valid & !in_stall
//  out     | out_valid, out_stall, pending/irq/next_*    | out_valid & !out_stall
//  cfg     | cfg_write_enable, cfg_index, cfg_data       | cfg_write_enable
//
// One item per cycle while in_stall is low; each result is registered (output or skid).
// Edge detect and pending update finish in the transfer cycle; output register plus skid.
// in_stall rises only when both output entries hold results.
// Reset clears config, edge history, pending bits and the output buffer.
`include "external_interrupt_edge_controller_unit_defines.svh"

module external_interrupt_edge_controller_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [exti_pkg::PORT_WIDTH-1:0]      port_a_levels,
    input  logic [exti_pkg::PORT_WIDTH-1:0]      port_b_levels,
    input  logic [exti_pkg::PORT_WIDTH-1:0]      port_c_levels,
    input  logic [exti_pkg::PORT_WIDTH-1:0]      port_d_levels,
    input  logic [exti_pkg::PORT_WIDTH-1:0]      pending_clear,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [exti_pkg::PORT_WIDTH-1:0]      pending_flags,
    output logic [exti_pkg::IRQ_WIDTH-1:0]       irq_requests,
    output logic [exti_pkg::LINE_ID_WIDTH-1:0]   next_line_mid,
    output logic                                 next_mid_valid,
    output logic [exti_pkg::LINE_ID_WIDTH-1:0]   next_line_high,
    output logic                                 next_high_valid,
    input  logic                                 cfg_write_enable,
    input  logic [exti_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [exti_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import exti_pkg::*;

    logic [CFG_DATA_WIDTH-1:0] port_select_reg;
    logic [PORT_WIDTH-1:0]     rise_en_reg;
    logic [PORT_WIDTH-1:0]     fall_en_reg;
    logic [PORT_WIDTH-1:0]     irq_mask_reg;

    logic [PORT_WIDTH-1:0]     prev_levels_reg;
    logic                      history_primed_reg;
    logic [PORT_WIDTH-1:0]     pending_reg;

    logic                      out_valid_reg;
    result_t                   out_data_reg;
    logic                      skid_valid_reg;
    result_t                   skid_data_reg;

    logic                      accept_in;
    logic                      out_take;
    logic [PORT_WIDTH-1:0]     levels;
    logic [PORT_WIDTH-1:0]     set_bits;
    logic [PORT_WIDTH-1:0]     pending_next;
    logic [PORT_WIDTH-1:0]     masked;
    result_t                   result;

    assign accept_in = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = skid_valid_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_select_reg <= '0;
            rise_en_reg     <= '0;
            fall_en_reg     <= '0;
            irq_mask_reg    <= '0;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PORT_SELECT: port_select_reg <= cfg_data;
                CFG_RISE_EN:     rise_en_reg     <= cfg_data[PORT_WIDTH-1:0];
                CFG_FALL_EN:     fall_en_reg     <= cfg_data[PORT_WIDTH-1:0];
                CFG_IRQ_MASK:    irq_mask_reg    <= cfg_data[PORT_WIDTH-1:0];
                default:         ;
            endcase
        end
    end

    // per-line pin select; unknown codes read port A
    always_comb
    begin
        logic [SELECT_WIDTH-1:0] sel;
        levels = '0;
        for (int n = 0; n < PORT_WIDTH; n++)
        begin
            sel = port_select_reg[n*SELECT_WIDTH +: SELECT_WIDTH];
            case (sel)
                SELECT_WIDTH'(PORT_B): levels[n] = port_b_levels[n];
                SELECT_WIDTH'(PORT_C): levels[n] = port_c_levels[n];
                SELECT_WIDTH'(PORT_D): levels[n] = port_d_levels[n];
                default:               levels[n] = port_a_levels[n];
            endcase
        end
        levels = levels & LINE_MASK;
    end

    always_comb
    begin
        if (history_primed_reg)
            set_bits = ((levels & ~prev_levels_reg & rise_en_reg)
                      | (~levels & prev_levels_reg & fall_en_reg)) & LINE_MASK;
        else
            set_bits = '0;
        pending_next = ((pending_reg & ~pending_clear) | set_bits) & LINE_MASK;
    end

    // result fields from the updated pending bits
    always_comb
    begin
        masked                 = pending_next & irq_mask_reg;
        result.pending_flags   = pending_next;
        result.irq_requests    = {|(masked & HIGH_GROUP_MASK),
                                  |(masked & MID_GROUP_MASK),
                                  masked[DIRECT_IRQS-1:0]};
        result.next_line_mid   = LINE_ID_WIDTH'(MID_LO);
        result.next_mid_valid  = |(pending_next & MID_GROUP_MASK);
        result.next_line_high  = LINE_ID_WIDTH'(HIGH_LO);
        result.next_high_valid = |(pending_next & HIGH_GROUP_MASK);
        for (int n = MID_HI; n >= MID_LO; n--)
        begin
            if (pending_next[n])
                result.next_line_mid = LINE_ID_WIDTH'(n);
        end
        for (int n = HIGH_HI; n >= HIGH_LO; n--)
        begin
            if (pending_next[n])
                result.next_line_high = LINE_ID_WIDTH'(n);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_levels_reg    <= '0;
            history_primed_reg <= 1'b0;
            pending_reg        <= '0;
        end
        else if (accept_in)
        begin
            prev_levels_reg    <= levels;
            history_primed_reg <= 1'b1;
            pending_reg        <= pending_next;
        end
    end

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (accept_in)
        begin
            if (!out_valid_reg || out_take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            if (!out_valid_reg || out_take)
                out_data_reg <= result;
            else
                skid_data_reg <= result;
        end
        else if (out_take && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign pending_flags   = out_data_reg.pending_flags;
    assign irq_requests    = out_data_reg.irq_requests;
    assign next_line_mid   = out_data_reg.next_line_mid;
    assign next_mid_valid  = out_data_reg.next_mid_valid;
    assign next_line_high  = out_data_reg.next_line_high;
    assign next_high_valid = out_data_reg.next_high_valid;

    `EXTI_ASSERT(a_skid_implies_out, !skid_valid_reg || out_valid_reg, "skid full while output empty")
    `EXTI_ASSERT(a_pending_hold, !accept_in |=> $stable(pending_reg), "pending bits moved without a transfer")
    `EXTI_ASSERT(a_first_no_set, (accept_in && !history_primed_reg) |=> ((pending_reg & ~$past(pending_reg)) == '0), "edge set on priming sample")
    `EXTI_ASSERT(a_primed_after, accept_in |=> history_primed_reg, "history not primed after transfer")

endmodule

// ===== verif/external_interrupt_edge_controller_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for external_interrupt_edge_controller_unit: directed and random pin samples.
// Self-checking against an in-file edge/pending predictor; depends on exti_pkg and the RTL.
module external_interrupt_edge_controller_unit_tb;
    import exti_pkg::*;

    typedef struct packed {
        logic [PORT_WIDTH-1:0] port_a;
        logic [PORT_WIDTH-1:0] port_b;
        logic [PORT_WIDTH-1:0] port_c;
        logic [PORT_WIDTH-1:0] port_d;
        logic [PORT_WIDTH-1:0] clear_mask;
    } sample_t;

    class exti_scoreboard;
        logic [CFG_DATA_WIDTH-1:0] port_select;
        logic [PORT_WIDTH-1:0]     rise_en;
        logic [PORT_WIDTH-1:0]     fall_en;
        logic [PORT_WIDTH-1:0]     irq_mask;
        logic [PORT_WIDTH-1:0]     last_levels;
        bit                        primed;
        logic [PORT_WIDTH-1:0]     pending;
        result_t                   awaited[$];
        int                        errors;

        function new();
            port_select = '0;
            rise_en     = '0;
            fall_en     = '0;
            irq_mask    = '0;
            last_levels = '0;
            primed      = 1'b0;
            pending     = '0;
            errors      = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_WIDTH-1:0] value);
            case (idx)
                CFG_PORT_SELECT: port_select = value;
                CFG_RISE_EN:     rise_en = value[PORT_WIDTH-1:0];
                CFG_FALL_EN:     fall_en = value[PORT_WIDTH-1:0];
                CFG_IRQ_MASK:    irq_mask = value[PORT_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        // advance pending state by one accepted sample and queue the result
        function void note_sample(sample_t s);
            logic [PORT_WIDTH-1:0]   ports [4];
            logic [PORT_WIDTH-1:0]   levels;
            logic [PORT_WIDTH-1:0]   edges;
            logic [PORT_WIDTH-1:0]   masked;
            logic [SELECT_WIDTH-1:0] sel;
            result_t                 r;
            ports[PORT_A] = s.port_a;
            ports[PORT_B] = s.port_b;
            ports[PORT_C] = s.port_c;
            ports[PORT_D] = s.port_d;
            levels = '0;
            for (int n = 0; n < LINE_COUNT; n++) begin
                sel = port_select[SELECT_WIDTH*n +: SELECT_WIDTH];
                if (sel > SELECT_WIDTH'(PORT_D))
                    levels[n] = ports[PORT_A][n];
                else
                    levels[n] = ports[sel[1:0]][n];
            end
            levels &= LINE_MASK;
            edges = '0;
            if (primed)
                edges = ((levels & ~last_levels & rise_en) | (~levels & last_levels & fall_en))
                        & LINE_MASK;
            pending = ((pending & ~s.clear_mask) | edges) & LINE_MASK;
            last_levels = levels;
            primed = 1'b1;

            masked = pending & irq_mask;
            r.pending_flags = pending;
            r.irq_requests[DIRECT_IRQS-1:0] = masked[DIRECT_IRQS-1:0];
            r.irq_requests[5] = |(masked & MID_GROUP_MASK);
            r.irq_requests[6] = |(masked & HIGH_GROUP_MASK);
            r.next_line_mid = LINE_ID_WIDTH'(MID_LO);
            r.next_mid_valid = 1'b0;
            for (int n = MID_HI; n >= MID_LO; n--) begin
                if (pending[n]) begin
                    r.next_line_mid = LINE_ID_WIDTH'(n);
                    r.next_mid_valid = 1'b1;
                end
            end
            r.next_line_high = LINE_ID_WIDTH'(HIGH_LO);
            r.next_high_valid = 1'b0;
            for (int n = HIGH_HI; n >= HIGH_LO; n--) begin
                if (pending[n]) begin
                    r.next_line_high = LINE_ID_WIDTH'(n);
                    r.next_high_valid = 1'b1;
                end
            end
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, logic [PORT_WIDTH-1:0] exp_v,
                                    logic [PORT_WIDTH-1:0] got_v);
            if (exp_v !== got_v) begin
                $error("%s: expected %0h, got %0h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited.size() == 0) begin
                $error("result transfer with nothing outstanding");
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("pending_flags", want.pending_flags, got.pending_flags);
            compare_field("irq_requests", PORT_WIDTH'(want.irq_requests),
                          PORT_WIDTH'(got.irq_requests));
            compare_field("next_line_mid", PORT_WIDTH'(want.next_line_mid),
                          PORT_WIDTH'(got.next_line_mid));
            compare_field("next_mid_valid", PORT_WIDTH'(want.next_mid_valid),
                          PORT_WIDTH'(got.next_mid_valid));
            compare_field("next_line_high", PORT_WIDTH'(want.next_line_high),
                          PORT_WIDTH'(got.next_line_high));
            compare_field("next_high_valid", PORT_WIDTH'(want.next_high_valid),
                          PORT_WIDTH'(got.next_high_valid));
        endfunction

        function int waiting();
            return awaited.size();
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [PORT_WIDTH-1:0]      port_a_levels;
    logic [PORT_WIDTH-1:0]      port_b_levels;
    logic [PORT_WIDTH-1:0]      port_c_levels;
    logic [PORT_WIDTH-1:0]      port_d_levels;
    logic [PORT_WIDTH-1:0]      pending_clear;
    logic                       out_valid;
    logic                       out_stall;
    logic [PORT_WIDTH-1:0]      pending_flags;
    logic [IRQ_WIDTH-1:0]       irq_requests;
    logic [LINE_ID_WIDTH-1:0]   next_line_mid;
    logic                       next_mid_valid;
    logic [LINE_ID_WIDTH-1:0]   next_line_high;
    logic                       next_high_valid;
    logic                       cfg_write_enable;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    exti_scoreboard sb = new();
    int             send_idle_pct;
    int             stall_pct;
    sample_t        last_sample;

    external_interrupt_edge_controller_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .port_a_levels    (port_a_levels),
        .port_b_levels    (port_b_levels),
        .port_c_levels    (port_c_levels),
        .port_d_levels    (port_d_levels),
        .pending_clear    (pending_clear),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .pending_flags    (pending_flags),
        .irq_requests     (irq_requests),
        .next_line_mid    (next_line_mid),
        .next_mid_valid   (next_mid_valid),
        .next_line_high   (next_line_high),
        .next_high_valid  (next_high_valid),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: stall bursts, mostly short
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({pending_flags, irq_requests, next_line_mid, next_mid_valid,
                             next_line_high, next_high_valid});
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 99) >= send_idle_pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic sample_t make_sample(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                            logic [15:0] d, logic [15:0] clr);
        sample_t s;
        s.port_a = a;
        s.port_b = b;
        s.port_c = c;
        s.port_d = d;
        s.clear_mask = clr;
        return s;
    endfunction

    function automatic logic [15:0] random_word();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] random_select();
        logic [CFG_DATA_WIDTH-1:0] v;
        case ($urandom_range(0, 3))
            0: v = {$urandom, $urandom};
            1: for (int n = 0; n < LINE_COUNT; n++)
                   v[SELECT_WIDTH*n +: SELECT_WIDTH] = SELECT_WIDTH'($urandom_range(0, 3));
            2: v = '0;
            default: v = '1;
        endcase
        return v;
    endfunction

    // as many sparse toggles as full scrambles; some repeats and whole-port levels
    function automatic sample_t random_sample(sample_t prev);
        sample_t s;
        s = prev;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                s.port_a = 16'($urandom);
                s.port_b = 16'($urandom);
                s.port_c = 16'($urandom);
                s.port_d = 16'($urandom);
            end
            4, 5, 6, 7:
            begin
                s.port_a ^= 16'($urandom) & 16'($urandom) & 16'($urandom);
                s.port_b ^= 16'($urandom) & 16'($urandom) & 16'($urandom);
                s.port_c ^= 16'($urandom) & 16'($urandom) & 16'($urandom);
                s.port_d ^= 16'($urandom) & 16'($urandom) & 16'($urandom);
            end
            8: s = prev;
            default:
            begin
                s.port_a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                s.port_b = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                s.port_c = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                s.port_d = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
        endcase
        case ($urandom_range(0, 7))
            5: s.clear_mask = 16'($urandom);
            6: s.clear_mask = 16'(1) << $urandom_range(0, 15);
            7: s.clear_mask = 16'hFFFF;
            default: s.clear_mask = 16'h0000;
        endcase
        return s;
    endfunction

    task automatic send_sample(sample_t s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        port_a_levels <= s.port_a;
        port_b_levels <= s.port_b;
        port_c_levels <= s.port_c;
        port_d_levels <= s.port_d;
        pending_clear <= s.clear_mask;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_sample(s);
        last_sample = s;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.waiting() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_WIDTH-1:0] value);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    task automatic apply_regs(logic [63:0] sel, logic [15:0] rise, logic [15:0] fall,
                              logic [15:0] mask);
        drain();
        write_reg(CFG_PORT_SELECT, sel);
        write_reg(CFG_RISE_EN, {48'h0, rise});
        write_reg(CFG_FALL_EN, {48'h0, fall});
        write_reg(CFG_IRQ_MASK, {48'h0, mask});
        cfg_write_enable <= 1'b0;
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        port_a_levels    = '0;
        port_b_levels    = '0;
        port_c_levels    = '0;
        port_d_levels    = '0;
        pending_clear    = '0;
        cfg_write_enable = 1'b0;
        cfg_index        = CFG_PORT_SELECT;
        cfg_data         = '0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        last_sample      = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first sample only primes history; then set/clear interplay and group lookups
        apply_regs(64'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(make_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_sample(make_sample(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
        send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
        send_sample(make_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
        send_sample(make_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0020));
        send_sample(make_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h01C0));
        send_sample(make_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0200));
        send_sample(make_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h7C00));
        send_sample(make_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h8000));
        send_sample(make_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));

        // undefined port codes read port A; rising only, all masked
        apply_regs(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_sample(make_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_sample(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
        send_sample(make_sample(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
        send_sample(make_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));

        apply_regs(64'h3210_3210_3210_3210, 16'h0000, 16'hFFFF, 16'h8421);
        send_sample(make_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
        send_sample(make_sample(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_sample(make_sample(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000));
        send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));

        apply_regs(64'h4567_89AB_CDEF_0123, 16'hA5A5, 16'h5A5A, 16'h7BDE);
        send_sample(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
        send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_sample(make_sample(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000));

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 3)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 20; stall_pct = 25; end
                default: begin send_idle_pct = 50; stall_pct = 50; end
            endcase
            if (phase == 0)
                apply_regs('0, '0, '0, '0);
            else if (phase == 1)
                apply_regs('1, '1, '1, '1);
            else
                apply_regs(random_select(), random_word(), random_word(), random_word());
            for (int i = 0; i < 230; i++)
            begin
                if (i == 115)
                    drain();
                send_sample(random_sample(last_sample));
            end
        end

        drain();
        if (sb.errors == 0 && sb.waiting() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/exti_pkg.sv
src/external_interrupt_edge_controller_unit.sv
verif/external_interrupt_edge_controller_unit_tb.sv
